@@ rtl/ewc_pkg.sv @@
package ewc_pkg;

  localparam int MAX_BITS = 16;
  localparam int BINOM_ROWS = 8;
  localparam int CODE_W = 16;
  localparam int LOST_W = 13;
  localparam int LEN_W = 4;
  localparam int RANK_W = 4;
  localparam int CNT_W = 5;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // BINOM[r][n] holds C(n, r+1).
  localparam logic [CODE_W-1:0] BINOM [BINOM_ROWS][MAX_BITS] = '{
    '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
      16'd8, 16'd9, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14, 16'd15},
    '{16'd0, 16'd0, 16'd1, 16'd3, 16'd6, 16'd10, 16'd15, 16'd21,
      16'd28, 16'd36, 16'd45, 16'd55, 16'd66, 16'd78, 16'd91, 16'd105},
    '{16'd0, 16'd0, 16'd0, 16'd1, 16'd4, 16'd10, 16'd20, 16'd35,
      16'd56, 16'd84, 16'd120, 16'd165, 16'd220, 16'd286, 16'd364, 16'd455},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd5, 16'd15, 16'd35,
      16'd70, 16'd126, 16'd210, 16'd330, 16'd495, 16'd715, 16'd1001, 16'd1365},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd6, 16'd21,
      16'd56, 16'd126, 16'd252, 16'd462, 16'd792, 16'd1287, 16'd2002, 16'd3003},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd7,
      16'd28, 16'd84, 16'd210, 16'd462, 16'd924, 16'd1716, 16'd3003, 16'd5005},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1,
      16'd8, 16'd36, 16'd120, 16'd330, 16'd792, 16'd1716, 16'd3432, 16'd6435},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd1, 16'd9, 16'd45, 16'd165, 16'd495, 16'd1287, 16'd3003, 16'd6435}
  };

  // Code length, indexed by word width minus one and count minus one.
  localparam logic [LEN_W-1:0] LEN_ROM [MAX_BITS][BINOM_ROWS] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd3, 4'd4, 4'd4, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd3, 4'd4, 4'd5, 4'd4, 4'd3, 4'd0, 4'd0, 4'd0},
    '{4'd3, 4'd5, 4'd6, 4'd6, 4'd5, 4'd3, 4'd0, 4'd0},
    '{4'd3, 4'd5, 4'd6, 4'd7, 4'd6, 4'd5, 4'd3, 4'd0},
    '{4'd4, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd6, 4'd4},
    '{4'd4, 4'd6, 4'd7, 4'd8, 4'd8, 4'd8, 4'd7, 4'd6},
    '{4'd4, 4'd6, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9, 4'd8},
    '{4'd4, 4'd7, 4'd8, 4'd9, 4'd10, 4'd10, 4'd10, 4'd9},
    '{4'd4, 4'd7, 4'd9, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11},
    '{4'd4, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd12, 4'd12},
    '{4'd4, 4'd7, 4'd9, 4'd11, 4'd12, 4'd13, 4'd13, 4'd13},
    '{4'd4, 4'd7, 4'd10, 4'd11, 4'd13, 4'd13, 4'd14, 4'd14}
  };

  // Number of short codes lost by the truncated-binary code, same indexing.
  localparam logic [LOST_W-1:0] LOST_ROM [MAX_BITS][BINOM_ROWS] = '{
    '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd1, 13'd1, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd0, 13'd2, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd3, 13'd6, 13'd6, 13'd3, 13'd0, 13'd0, 13'd0, 13'd0},
    '{13'd2, 13'd1, 13'd12, 13'd1, 13'd2, 13'd0, 13'd0, 13'd0},
    '{13'd1, 13'd11, 13'd29, 13'd29, 13'd11, 13'd1, 13'd0, 13'd0},
    '{13'd0, 13'd4, 13'd8, 13'd58, 13'd8, 13'd4, 13'd0, 13'd0},
    '{13'd7, 13'd28, 13'd44, 13'd2, 13'd2, 13'd44, 13'd28, 13'd7},
    '{13'd6, 13'd19, 13'd8, 13'd46, 13'd4, 13'd46, 13'd8, 13'd19},
    '{13'd5, 13'd9, 13'd91, 13'd182, 13'd50, 13'd50, 13'd182, 13'd91},
    '{13'd4, 13'd62, 13'd36, 13'd17, 13'd232, 13'd100, 13'd232, 13'd17},
    '{13'd3, 13'd50, 13'd226, 13'd309, 13'd761, 13'd332, 13'd332, 13'd761},
    '{13'd2, 13'd37, 13'd148, 13'd23, 13'd46, 13'd1093, 13'd664, 13'd1093},
    '{13'd1, 13'd23, 13'd57, 13'd683, 13'd1093, 13'd3187, 13'd1757, 13'd1757},
    '{13'd0, 13'd8, 13'd464, 13'd228, 13'd3824, 13'd184, 13'd4944, 13'd3514}
  };

  // One item as it travels down the row of cells. On encode, word is the
  // folded input word, acc the running sum and rank the set bits seen so far
  // (held at eight). On decode, word collects the recovered bits, acc the
  // remaining index and rank the set bits still to be found.
  typedef struct packed {
    logic              op;
    logic              err;
    logic [CODE_W-1:0] word;
    logic [CODE_W-1:0] acc;
    logic [RANK_W-1:0] rank;
    logic [LEN_W-1:0]  len;
    logic [LOST_W-1:0] lost;
    logic [LEN_W-1:0]  dlen;
  } ewc_item_t;

endpackage

@@ rtl/ewc_prep.sv @@
module ewc_prep #(
  parameter int WORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic                       op,
  input  logic [15:0]                pattern_word,
  input  logic [4:0]                 ones_count,
  input  logic [15:0]                stream_window,
  output logic                       out_valid,
  output ewc_pkg::ewc_item_t         out_item
);

  localparam int ROW = WORD_BITS - 1;
  localparam int HALF = (WORD_BITS + 1) / 2;
  localparam logic [15:0] WMASK = 16'((32'd1 << WORD_BITS) - 32'd1);

  ewc_pkg::ewc_item_t item_next;
  logic        bad;
  logic        fold;
  logic [3:0]  cnt;
  logic [2:0]  idx;
  logic [3:0]  len;
  logic [12:0] lost;
  logic [3:0]  shortlen;
  logic [15:0] code_s;
  logic        nb;
  logic [15:0] fold_mask;

  always_comb begin
    bad = (ones_count == 5'd0) || (ones_count >= 5'(WORD_BITS));
    fold = ones_count > 5'(HALF);
    cnt = fold ? 4'(5'(WORD_BITS) - ones_count) : ones_count[3:0];
    idx = 3'(cnt - 4'd1);
    len = ewc_pkg::LEN_ROM[ROW][idx];
    lost = ewc_pkg::LOST_ROM[ROW][idx];
    shortlen = (len != 4'd0) ? len - 4'd1 : 4'd0;
    code_s = (shortlen != 4'd0) ? (stream_window >> (5'd16 - {1'b0, shortlen})) : 16'd0;
    nb = stream_window[4'd15 - shortlen];
    fold_mask = fold ? WMASK : 16'd0;

    item_next.op = op;
    item_next.err = bad;
    item_next.len = len;
    item_next.lost = lost;
    if (op == ewc_pkg::OP_ENCODE) begin
      item_next.word = (pattern_word & WMASK) ^ fold_mask;
      item_next.acc = 16'd0;
      item_next.rank = 4'd0;
      item_next.dlen = 4'd0;
    end else begin
      item_next.word = fold_mask;
      item_next.rank = cnt;
      if (code_s >= {3'b000, lost}) begin
        item_next.acc = {code_s[14:0], nb} - {3'b000, lost};
        item_next.dlen = shortlen + 4'd1;
      end else begin
        item_next.acc = code_s;
        item_next.dlen = shortlen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/ewc_cell.sv @@
module ewc_cell #(
  parameter int ENC_POS = 0,
  parameter int DEC_POS = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ewc_pkg::ewc_item_t in_item,
  output logic               out_valid,
  output ewc_pkg::ewc_item_t out_item
);

  ewc_pkg::ewc_item_t item_next;
  logic [15:0] c_dec;

  always_comb begin
    item_next = in_item;
    c_dec = ewc_pkg::BINOM[3'(in_item.rank - 4'd1)][DEC_POS];
    if (in_item.op == ewc_pkg::OP_ENCODE) begin
      if (in_item.word[ENC_POS] && (in_item.rank < 4'd8)) begin
        item_next.acc = in_item.acc + ewc_pkg::BINOM[in_item.rank[2:0]][ENC_POS];
        item_next.rank = in_item.rank + 4'd1;
      end
    end else begin
      if ((in_item.rank != 4'd0) && (in_item.acc >= c_dec)) begin
        item_next.word[DEC_POS] = ~in_item.word[DEC_POS];
        item_next.acc = in_item.acc - c_dec;
        item_next.rank = in_item.rank - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/ewc_out.sv @@
module ewc_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ewc_pkg::ewc_item_t in_item,
  output logic               out_valid,
  output logic [15:0]        out_value,
  output logic [3:0]         out_length,
  output logic               out_error
);

  logic [15:0] value_next;
  logic [3:0]  length_next;
  logic [3:0]  shortlen;
  logic [15:0] enc_value;
  logic [15:0] len_mask;

  always_comb begin
    shortlen = (in_item.len != 4'd0) ? in_item.len - 4'd1 : 4'd0;
    if (in_item.acc < {3'b000, in_item.lost}) begin
      enc_value = in_item.acc;
      length_next = shortlen;
    end else begin
      enc_value = in_item.acc + {3'b000, in_item.lost};
      length_next = in_item.len;
    end
    len_mask = 16'((17'd1 << length_next) - 17'd1);
    value_next = enc_value & len_mask;
    if (in_item.op == ewc_pkg::OP_DECODE) begin
      value_next = in_item.word;
      length_next = in_item.dlen;
    end
    if (in_item.err) begin
      value_next = 16'd0;
      length_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= value_next;
      out_length <= length_next;
      out_error <= in_item.err;
    end
  end

endmodule

@@ rtl/enumerative_word_codec_core.sv @@
// Enumerative codec for one WORD_BITS-wide word with a known count of set
// bits. Each item is either an encode, which turns the word into its
// truncated-binary rank code right-aligned with its bit length, or a decode,
// which recovers the word from the next sixteen stream bits and reports how
// many of them were consumed. A count of zero or of WORD_BITS and above
// returns the error flag with zero value and length. The block accepts one
// item every cycle while the output is not stalled, and each item passes
// through its stages in order: one stage looks up the code tables and reads
// the stream window, a row of WORD_BITS cells handles one bit position each,
// and a last stage forms the code and drives the output register. The whole
// pipeline advances whenever the output register is empty or being taken.
module enumerative_word_codec_core #(
  parameter int WORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pattern_word [15:0], ones_count [20:16], stream_window [36:21], zero [39:37]
  input  logic [39:0] s_tdata,
  // op [0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_value [15:0], out_length [19:16], zero [23:20]
  output logic [23:0] m_tdata,
  // error [0]
  output logic [0:0]  m_tuser
);

  logic               advance;
  logic               stage_valid [WORD_BITS+1];
  ewc_pkg::ewc_item_t stage_item  [WORD_BITS+1];
  logic [15:0]        out_value;
  logic [3:0]         out_length;
  logic               out_error;

  assign advance = !m_tvalid || m_tready;
  assign s_tready = advance;

  ewc_prep #(
    .WORD_BITS(WORD_BITS)
  ) u_prep (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .in_valid      (s_tvalid),
    .op            (s_tuser[0]),
    .pattern_word  (s_tdata[15:0]),
    .ones_count    (s_tdata[20:16]),
    .stream_window (s_tdata[36:21]),
    .out_valid     (stage_valid[0]),
    .out_item      (stage_item[0])
  );

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_cell
    ewc_cell #(
      .ENC_POS(k),
      .DEC_POS(WORD_BITS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (stage_valid[k]),
      .in_item   (stage_item[k]),
      .out_valid (stage_valid[k+1]),
      .out_item  (stage_item[k+1])
    );
  end

  ewc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .in_valid   (stage_valid[WORD_BITS]),
    .in_item    (stage_item[WORD_BITS]),
    .out_valid  (m_tvalid),
    .out_value  (out_value),
    .out_length (out_length),
    .out_error  (out_error)
  );

  assign m_tdata = {4'b0000, out_length, out_value};
  assign m_tuser = out_error;

endmodule

@@ rtl/ewc_checker.sv @@
module ewc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 24'd0)
    else $error("Error result carries nonzero data.");

  a_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[19:16] <= 4'd14 && m_tdata[23:20] == 4'd0)
    else $error("Result length out of range.");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("Input stalled while output is drained.");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result shown right after reset.");

endmodule

bind enumerative_word_codec_core ewc_checker u_ewc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ bench/tb_top.sv @@
module tb_top;

  localparam int WORD_W = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CALM_TAIL = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        op;
    logic [15:0] word;
    logic [4:0]  count;
    logic [15:0] window;
  } codec_req_t;

  typedef struct {
    logic [15:0] value;
    logic [3:0]  length;
    logic        error;
  } codec_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;

  codec_req_t codec_requests[$];
  codec_res_t predicted_outputs[$];
  codec_req_t on_bus;
  int         send_gap = 0;
  int         recv_stall = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  enumerative_word_codec_core #(.WORD_BITS(WORD_W)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned choose(int n, int k);
    int unsigned acc;
    int i;
    if (k < 0 || k > n) return 0;
    acc = 1;
    for (i = 0; i < k; i++) acc = acc * (n - i) / (i + 1);
    return acc;
  endfunction

  function automatic codec_res_t predict_codec(codec_req_t q);
    codec_res_t res;
    int unsigned k, total, len, lost, shortlen, sum, rank, code, nb, c, value;
    int r, n, i;
    logic [15:0] fold, w, bits;
    res.value = '0;
    res.length = '0;
    res.error = 1'b0;
    k = q.count;
    if (k == 0 || k >= WORD_W) begin
      res.error = 1'b1;
      return res;
    end
    fold = '0;
    if (k > (WORD_W + 1) / 2) begin
      k = WORD_W - k;
      fold = '1;
    end
    // Truncated-binary code over all words of this weight.
    total = choose(WORD_W, k);
    len = 0;
    while ((1 << len) < total) len++;
    lost = (1 << len) - total;
    shortlen = (len > 0) ? len - 1 : 0;
    if (q.op == ewc_pkg::OP_ENCODE) begin
      w = q.word ^ fold;
      sum = 0;
      rank = 0;
      for (i = 0; i < WORD_W; i++) begin
        if (w[i]) begin
          if (rank < 8) sum += choose(i, rank + 1);
          rank++;
        end
      end
      if (sum < lost) begin
        value = sum;
        res.length = 4'(shortlen);
      end else begin
        value = sum + lost;
        res.length = 4'(len);
      end
      res.value = 16'(value & ((1 << res.length) - 1));
    end else begin
      code = (shortlen != 0) ? (q.window >> (16 - shortlen)) : 0;
      res.length = 4'(shortlen);
      if (code >= lost) begin
        nb = (q.window >> (15 - shortlen)) & 1;
        code = ((code << 1) | nb) - lost;
        res.length = 4'(shortlen + 1);
      end
      bits = fold;
      r = k - 1;
      n = WORD_W - 1;
      while (r >= 0 && n >= 0) begin
        c = choose(n, r + 1);
        if (code >= c) begin
          bits[n] = ~bits[n];
          code -= c;
          r--;
        end
        n--;
      end
      res.value = bits;
    end
    return res;
  endfunction

  function automatic logic [15:0] word_of_weight(int k);
    logic [15:0] w;
    w = '0;
    while ($countones(w) < k) w[$urandom_range(15, 0)] = 1'b1;
    return w;
  endfunction

  task automatic add_item(logic op, logic [15:0] word, logic [4:0] count,
                          logic [15:0] window);
    codec_req_t q;
    q.op = op;
    q.word = word;
    q.count = count;
    q.window = window;
    codec_requests.push_back(q);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) predicted_outputs.push_back(predict_codec(on_bus));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (codec_requests.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 15);
        s_tvalid <= 1'b0;
      end else if (codec_requests.size() > 0) begin
        on_bus = codec_requests.pop_front();
        s_tdata <= {3'b000, on_bus.window, on_bus.count, on_bus.word};
        s_tuser <= on_bus.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    codec_res_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value=%h length=%0d error=%b",
                     m_tdata[15:0], m_tdata[19:16], m_tuser[0]);
        end else begin
          exp_res = predicted_outputs.pop_front();
          if (m_tdata[15:0] !== exp_res.value || m_tdata[19:16] !== exp_res.length ||
              m_tuser[0] !== exp_res.error) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected value=%h length=%0d error=%b,",
                        " got value=%h length=%0d error=%b"},
                       exp_res.value, exp_res.length, exp_res.error,
                       m_tdata[15:0], m_tdata[19:16], m_tuser[0]);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_tready <= 1'b0;
      end else if (codec_requests.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        recv_stall <= $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    codec_res_t enc;
    codec_req_t probe;
    int pick, k, i;
    logic [31:0] win;

    add_item(ewc_pkg::OP_ENCODE, 16'h0001, 5'd1, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'h8000, 5'd1, 16'hFFFF);
    add_item(ewc_pkg::OP_ENCODE, 16'hFF00, 5'd8, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'h00FF, 5'd8, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'h007F, 5'd7, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'hFE00, 5'd7, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'hFF80, 5'd9, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'h7FFF, 5'd15, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'hFFFF, 5'd0, 16'hFFFF);
    add_item(ewc_pkg::OP_ENCODE, 16'h1234, 5'd16, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'hFFFF, 5'd31, 16'hFFFF);
    // The count need not match the word; ranks past eight add nothing.
    add_item(ewc_pkg::OP_ENCODE, 16'hFFFF, 5'd1, 16'h0000);
    add_item(ewc_pkg::OP_ENCODE, 16'h0000, 5'd3, 16'h0000);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd1, 16'h0000);
    add_item(ewc_pkg::OP_DECODE, 16'hFFFF, 5'd1, 16'hFFFF);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd8, 16'h0000);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd8, 16'hFFFF);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd15, 16'hFFFF);
    add_item(ewc_pkg::OP_DECODE, 16'hFFFF, 5'd9, 16'h8000);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd5, 16'hFFFF);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd0, 16'h1234);
    add_item(ewc_pkg::OP_DECODE, 16'h0000, 5'd17, 16'hFFFF);
    add_item(ewc_pkg::OP_DECODE, 16'hFFFF, 5'd31, 16'h0000);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(1, WORD_W - 1);
      if (pick < 40) begin
        add_item(ewc_pkg::OP_ENCODE, word_of_weight(k), 5'(k), 16'($urandom));
      end else if (pick < 75) begin
        // Decode a genuine code followed by random stream bits.
        probe.op = ewc_pkg::OP_ENCODE;
        probe.word = word_of_weight(k);
        probe.count = 5'(k);
        probe.window = '0;
        enc = predict_codec(probe);
        win = ({16'h0000, enc.value} << (16 - enc.length)) |
              ($urandom & ((32'd1 << (16 - enc.length)) - 1));
        add_item(ewc_pkg::OP_DECODE, 16'($urandom), 5'(k), win[15:0]);
      end else begin
        add_item(1'($urandom_range(0, 1)), 16'($urandom), 5'($urandom_range(0, 31)),
                 16'($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (codec_requests.size() != 0 || s_tvalid || predicted_outputs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
